// ===== rtl/cpfl_pkg.sv =====
`timescale 1ns / 1ps
package cpfl_pkg;

  // Frame store and counter sizing
  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
  localparam int CNT_W       = (LEN_W > 7) ? LEN_W : 7;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Frame header bytes
  localparam logic [7:0] HDR_B0 = 8'h55;
  localparam logic [7:0] HDR_B1 = 8'hFF;
  localparam logic [7:0] HDR_B2 = 8'h00;

  localparam logic [6:0] LIMIT_RESET = 7'd64;
  localparam logic [6:0] COUNT_MAX   = 7'd127;

  // Input mode codes
  localparam logic MODE_SEND = 1'b0;
  localparam logic MODE_RECV = 1'b1;

  // Result kind codes
  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Exchange status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_RESP  = 2'd1;
  localparam logic [1:0] STAT_BAD_LINK = 2'd2;
  localparam logic [1:0] STAT_BAD_RESP = 2'd3;

  // Classified item handed from front to back
  typedef struct packed {
    logic       is_recv;
    logic [7:0] data;
    logic       last;
  } item_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
    logic [6:0] count;
    logic       eor;
  } res_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      default: b = HDR_B2;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/cpfl_front.sv =====
`timescale 1ns / 1ps
module cpfl_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_mode,
  input  logic [7:0]      in_data,
  input  logic            in_last,
  input  logic            pop,
  output cpfl_pkg::q_head_t head
);
  import cpfl_pkg::*;

  item_t            q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  logic             push;
  logic             do_pop;
  item_t            new_item;

  // Classify the incoming item
  always_comb begin
    new_item.is_recv = (in_mode == MODE_RECV);
    new_item.data    = in_data;
    new_item.last    = in_last;
  end

  assign in_ready   = (cnt_r != Q_CW'(Q_DEPTH));
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the accepted item
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== rtl/cpfl_back.sv =====
`timescale 1ns / 1ps
module cpfl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cpfl_pkg::q_head_t head,
  output logic              pop,
  input  logic [6:0]        reply_limit,
  output logic              res_valid,
  input  logic              res_ready,
  output cpfl_pkg::res_t    res
);
  import cpfl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEND = 4'b0010,
    ST_RX   = 4'b0100,
    ST_STAT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  item_t            cur_r, cur_nxt;
  logic [6:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0] sent_len_r, sent_len_nxt;
  logic [7:0]       send_sum_r, send_sum_nxt;
  logic             frame_open_r, frame_open_nxt;
  logic [CNT_W-1:0] rx_pos_r, rx_pos_nxt;
  logic             echo_fail_r, echo_fail_nxt;
  logic             reply_fail_r, reply_fail_nxt;
  logic [7:0]       half_r, half_nxt;
  logic [15:0]      held_r, held_nxt;
  logic             held_v_r, held_v_nxt;
  logic [7:0]       rx_sum_r, rx_sum_nxt;
  logic [CNT_W-1:0] pairs_r, pairs_nxt;
  res_t             res_r, res_nxt;
  logic             res_valid_r, res_valid_nxt;

  // Frame store
  logic [7:0]       mem [FRAME_BYTES];
  logic [7:0]       rd_data_r;
  logic             mem_we;
  logic [7:0]       mem_wdata;

  logic             out_free;
  logic             emit;

  // Send start terms
  logic             hdr;
  logic [CNT_W:0]   base;
  logic             fits;
  logic [7:0]       sum0;

  // Send slot selection
  logic [6:0]       low;
  logic [2:0]       sel;
  logic [7:0]       slot_val;

  // Receive terms
  logic [CNT_W-1:0] rel;
  logic [CNT_W-1:0] m;
  logic [7:0]       pa, pb;
  logic [1:0]       st;
  logic [6:0]       cnt_out;

  assign out_free  = !res_valid_r || res_ready;
  assign pop       = (state_r == ST_IDLE) && head.valid && out_free;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Lowest pending slot of the send sequence
  always_comb begin
    low = slot_r & (~slot_r + 7'd1);
    sel = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (slot_r[i]) begin
        sel = 3'(i);
      end
    end
    case (sel)
      3'd0, 3'd1, 3'd2: slot_val = hdr_byte(sel[1:0]);
      3'd3:             slot_val = cur_r.data;
      3'd4:             slot_val = ~cur_r.data;
      3'd5:             slot_val = send_sum_r;
      default:          slot_val = ~send_sum_r;
    endcase
  end

  // Send start planning
  always_comb begin
    hdr  = !frame_open_r;
    base = hdr ? (CNT_W + 1)'(3) : {1'b0, sent_len_r};
    fits = (base + (CNT_W + 1)'(4)) <= (CNT_W + 1)'(FRAME_BYTES);
    sum0 = hdr ? 8'h00 : send_sum_r;
  end

  // Exchange status
  always_comb begin
    m       = rx_pos_r - sent_len_r;
    pa      = held_r[15:8];
    pb      = held_r[7:0];
    cnt_out = 7'd0;
    if (echo_fail_r || (rx_pos_r < sent_len_r)) begin
      st = STAT_BAD_LINK;
    end else if (rx_pos_r == sent_len_r) begin
      st = STAT_NO_RESP;
    end else if (reply_fail_r || (m < CNT_W'(5)) || !m[0] || !held_v_r) begin
      st = STAT_BAD_RESP;
    end else if ((pa != ~pb) || (pa != rx_sum_r)) begin
      st = STAT_BAD_RESP;
    end else begin
      st      = STAT_OK;
      cnt_out = (pairs_r > CNT_W'(COUNT_MAX)) ? COUNT_MAX : pairs_r[6:0];
    end
  end

  assign rel = rx_pos_r - sent_len_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    slot_nxt       = slot_r;
    sent_len_nxt   = sent_len_r;
    send_sum_nxt   = send_sum_r;
    frame_open_nxt = frame_open_r;
    rx_pos_nxt     = rx_pos_r;
    echo_fail_nxt  = echo_fail_r;
    reply_fail_nxt = reply_fail_r;
    half_nxt       = half_r;
    held_nxt       = held_r;
    held_v_nxt     = held_v_r;
    rx_sum_nxt     = rx_sum_r;
    pairs_nxt      = pairs_r;
    res_nxt        = res_r;
    emit           = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = slot_val;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          cur_nxt = head.item;
          if (head.item.is_recv) begin
            state_nxt = ST_RX;
          end else begin
            // Plan header, data pair and sum pair slots
            slot_nxt       = {head.item.last, head.item.last, fits, fits, hdr, hdr, hdr};
            sent_len_nxt   = hdr ? '0 : sent_len_r;
            send_sum_nxt   = fits ? sum0 + head.item.data : sum0;
            frame_open_nxt = !head.item.last;
            if (hdr || fits || head.item.last) begin
              state_nxt = ST_SEND;
            end
          end
        end
      end

      ST_SEND: begin
        if (out_free) begin
          // Emit one line byte and store it for the echo check
          emit          = 1'b1;
          res_nxt.kind  = KIND_LINE;
          res_nxt.value = slot_val;
          res_nxt.status = STAT_OK;
          res_nxt.count = 7'd0;
          res_nxt.eor   = ((slot_r & ~low) == 7'd0);
          slot_nxt      = slot_r & ~low;
          if (sent_len_r < CNT_W'(FRAME_BYTES)) begin
            mem_we       = 1'b1;
            sent_len_nxt = sent_len_r + 1'b1;
          end
          if ((slot_r & ~low) == 7'd0) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_RX: begin
        if (out_free) begin
          res_nxt.kind   = KIND_DATA;
          res_nxt.value  = held_r[15:8];
          res_nxt.status = STAT_OK;
          res_nxt.count  = 7'd0;
          res_nxt.eor    = !cur_r.last;
          if (rx_pos_r < CNT_W'(FRAME_BYTES)) begin
            rx_pos_nxt = rx_pos_r + 1'b1;
            if (rx_pos_r < sent_len_r) begin
              // Echo byte
              if (rd_data_r != cur_r.data) begin
                echo_fail_nxt = 1'b1;
              end
            end else if (!echo_fail_r) begin
              if (rel < CNT_W'(3)) begin
                // Reply header byte
                if (cur_r.data != hdr_byte(rel[1:0])) begin
                  reply_fail_nxt = 1'b1;
                end
              end else if (rel[0]) begin
                half_nxt = cur_r.data;
              end else begin
                // Second byte of a pair: confirm the held pair
                if (held_v_r && !reply_fail_r) begin
                  if (held_r[15:8] != ~held_r[7:0]) begin
                    reply_fail_nxt = 1'b1;
                  end else begin
                    rx_sum_nxt = rx_sum_r + held_r[15:8];
                    if (pairs_r < CNT_W'(reply_limit)) begin
                      emit = 1'b1;
                    end
                    pairs_nxt = pairs_r + 1'b1;
                  end
                end
                held_nxt   = {half_r, cur_r.data};
                held_v_nxt = 1'b1;
              end
            end
          end
          state_nxt = cur_r.last ? ST_STAT : ST_IDLE;
        end
      end

      ST_STAT: begin
        if (out_free) begin
          // Emit status and clear the burst
          emit           = 1'b1;
          res_nxt.kind   = KIND_STATUS;
          res_nxt.value  = 8'h00;
          res_nxt.status = st;
          res_nxt.count  = cnt_out;
          res_nxt.eor    = 1'b1;
          rx_pos_nxt     = '0;
          echo_fail_nxt  = 1'b0;
          reply_fail_nxt = 1'b0;
          half_nxt       = 8'h00;
          held_nxt       = 16'h0000;
          held_v_nxt     = 1'b0;
          rx_sum_nxt     = 8'h00;
          pairs_nxt      = '0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Hold or drop the output register
    if (emit) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sent_len_r   <= '0;
      send_sum_r   <= 8'h00;
      frame_open_r <= 1'b0;
      rx_pos_r     <= '0;
      echo_fail_r  <= 1'b0;
      reply_fail_r <= 1'b0;
      half_r       <= 8'h00;
      held_r       <= 16'h0000;
      held_v_r     <= 1'b0;
      rx_sum_r     <= 8'h00;
      pairs_r      <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sent_len_r   <= sent_len_nxt;
      send_sum_r   <= send_sum_nxt;
      frame_open_r <= frame_open_nxt;
      rx_pos_r     <= rx_pos_nxt;
      echo_fail_r  <= echo_fail_nxt;
      reply_fail_r <= reply_fail_nxt;
      half_r       <= half_nxt;
      held_r       <= held_nxt;
      held_v_r     <= held_v_nxt;
      rx_sum_r     <= rx_sum_nxt;
      pairs_r      <= pairs_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    slot_r <= slot_nxt;
    res_r  <= res_nxt;
  end

  // Frame store: write on send, registered read at the receive position
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sent_len_r[ADDR_W-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[rx_pos_r[ADDR_W-1:0]];
  end

endmodule

// ===== rtl/complement_pair_frame_link_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  tdata (low bit up)                         tuser   tlast
// in_      input      data[7:0]                                  mode    last
// out_     output     value[7:0] status[9:8] reply_count[16:10]  kind    end_of_run
// cfg_     input      reply_limit[6:0] on cfg_wr_en              -       -
//
// A send item is dequeued and then sent as up to 7 line bytes, one result each;
// the back sequencer emits one result per cycle while the output is not stalled.
// A receive item is dequeued while the frame store is read, then checked, and,
// when it ends a burst, followed by a status result.
// A four-entry queue lets input be taken while the back works or the output stalls.
// Reset (rst_n low, synchronous) clears the frame state; the frame store needs no clear.
module complement_pair_frame_link_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data
  input  logic        in_tuser,   // mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value, status, reply_count, zero fill
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);
  import cpfl_pkg::*;

  logic [6:0] reply_limit_r;
  q_head_t    head;
  logic       pop;
  res_t       res;

  // Reply limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      reply_limit_r <= cfg_wr_data;
    end
  end

  cpfl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .pop      (pop),
    .head     (head)
  );

  cpfl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .reply_limit (reply_limit_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  // Pack the result item
  assign out_tdata = {7'd0, res.count, res.status, res.value};
  assign out_tuser = res.kind;
  assign out_tlast = res.eor;

endmodule
